@@ rtl/mco_pkg.sv @@
package mco_pkg;

    localparam int COORD_W  = 13;
    localparam int POINT_W  = 14;
    localparam int RADIUS_W = 12;
    localparam int CHAN_W   = 8;
    localparam int COLOUR_W = 32;
    localparam int DEC_W    = 16;
    localparam int INDEX_W  = 3;

    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 64;

    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    localparam logic [INDEX_W-1:0] INDEX_LAST = 3'd7;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [POINT_W-1:0] point_t;
    typedef logic signed [DEC_W-1:0]   dec_t;

endpackage

@@ rtl/midpoint_circle_outline_top.sv @@
// an accepted advance word is captured into the burst registers, and each point then passes through the output register
// an advance that draws gives eight points, one point per cycle on the output while m_tready does not stall it
// a start, or an advance with no circle left, gives no output
// the output register lets the next advance be accepted while the eighth point is loaded
// reset is asynchronous, active low; it leaves the generator idle with no circle loaded
module midpoint_circle_outline_top #(
    parameter int RADIUS_MAX = 4095
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // center_x, center_y, radius, red, green, blue, alpha, zero pad
    input  logic [mco_pkg::S_DATA_W-1:0] s_tdata,
    // command
    input  logic                         s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // point_x, point_y, point_index, pixel_colour, zero pad
    output logic [mco_pkg::M_DATA_W-1:0] m_tdata,
    // last_of_step
    output logic                         m_tlast,
    // circle_done
    output logic                         m_tuser
);

    import mco_pkg::*;

    localparam logic [16:0] RMAX = 17'(RADIUS_MAX);

    // generator state
    logic                  active_reg, active_next;
    coord_t                col_reg, col_next;
    coord_t                row_reg, row_next;
    coord_t                sx_reg, sx_next;
    coord_t                sy_reg, sy_next;
    dec_t                  dec_reg, dec_next;
    logic [COLOUR_W-1:0]   colour_reg, colour_next;

    // burst of eight points
    logic                  burst_reg, burst_next;
    logic [INDEX_W-1:0]    idx_reg, idx_next;
    coord_t                bcol_reg, brow_reg, bx_reg, by_reg;
    logic [COLOUR_W-1:0]   bcolour_reg;
    logic                  bdone_reg;

    // output register
    logic                  m_valid_reg, m_valid_next;
    point_t                out_x_reg, out_y_reg;
    logic [INDEX_W-1:0]    out_idx_reg;
    logic [COLOUR_W-1:0]   out_colour_reg;
    logic                  out_last_reg, out_done_reg;

    logic                  in_acc;
    logic                  out_load;
    logic                  adv_ok;
    logic                  fire;
    logic [RADIUS_W-1:0]   r_in, r_sat;
    logic [DEC_W-1:0]      dec_num;
    dec_t                  dec_init;
    dec_t                  dec_upd;
    coord_t                sx_upd, sy_upd;
    logic                  done_upd;
    coord_t                ofs_a, ofs_b;
    point_t                px, py;

    assign out_load = burst_reg && (!m_valid_reg || m_tready);
    assign s_tready = !burst_reg || (out_load && (idx_reg == INDEX_LAST));
    assign in_acc   = s_tvalid && s_tready;
    assign adv_ok   = active_reg && (sx_reg <= sy_reg);
    assign fire     = in_acc && (s_tuser == CMD_ADVANCE) && adv_ok;

    // start values
    assign r_in     = s_tdata[37:26];
    assign r_sat    = ({5'd0, r_in} > RMAX) ? RMAX[RADIUS_W-1:0] : r_in;
    assign dec_num  = {2'b00, r_sat, 2'b00} - 16'd5;
    assign dec_init = (r_sat < 12'd2) ? '0 : -dec_t'(dec_num >> 3);

    // one midpoint iteration
    always_comb
    begin
        sy_upd = sy_reg;
        if (dec_reg[DEC_W-1])
        begin
            dec_upd = dec_reg + (dec_t'(sx_reg) <<< 1) + 16'sd1;
        end
        else
        begin
            dec_upd = dec_reg + ((dec_t'(sx_reg) - dec_t'(sy_reg)) <<< 1) + 16'sd1;
            sy_upd  = sy_reg - 13'sd1;
        end
        sx_upd   = sx_reg + 13'sd1;
        done_upd = sx_upd > sy_upd;
    end

    always_comb
    begin
        active_next = active_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        sx_next     = sx_reg;
        sy_next     = sy_reg;
        dec_next    = dec_reg;
        colour_next = colour_reg;
        if (in_acc)
        begin
            if (s_tuser == CMD_START)
            begin
                active_next = 1'b1;
                col_next    = s_tdata[12:0];
                row_next    = s_tdata[25:13];
                sx_next     = '0;
                sy_next     = coord_t'({1'b0, r_sat});
                dec_next    = dec_init;
                colour_next = {s_tdata[45:38], s_tdata[53:46], s_tdata[61:54], s_tdata[69:62]};
            end
            else if (adv_ok)
            begin
                sx_next     = sx_upd;
                sy_next     = sy_upd;
                dec_next    = dec_upd;
                active_next = !done_upd;
            end
            else
            begin
                active_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        burst_next = burst_reg;
        idx_next   = idx_reg;
        if (out_load)
        begin
            idx_next = idx_reg + 3'd1;
            if (idx_reg == INDEX_LAST)
            begin
                burst_next = 1'b0;
            end
        end
        if (fire)
        begin
            burst_next = 1'b1;
            idx_next   = '0;
        end
    end

    // point selection: bit 2 swaps x and y, bit 0 negates column, bit 1 negates row
    assign ofs_a = idx_reg[2] ? by_reg : bx_reg;
    assign ofs_b = idx_reg[2] ? bx_reg : by_reg;
    assign px    = idx_reg[0] ? point_t'(bcol_reg) - point_t'(ofs_a)
                              : point_t'(bcol_reg) + point_t'(ofs_a);
    assign py    = idx_reg[1] ? point_t'(brow_reg) - point_t'(ofs_b)
                              : point_t'(brow_reg) + point_t'(ofs_b);

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (out_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            col_reg     <= '0;
            row_reg     <= '0;
            sx_reg      <= '0;
            sy_reg      <= '0;
            dec_reg     <= '0;
            colour_reg  <= '0;
            burst_reg   <= 1'b0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg  <= active_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            sx_reg      <= sx_next;
            sy_reg      <= sy_next;
            dec_reg     <= dec_next;
            colour_reg  <= colour_next;
            burst_reg   <= burst_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            bcol_reg    <= col_reg;
            brow_reg    <= row_reg;
            bx_reg      <= sx_reg;
            by_reg      <= sy_reg;
            bcolour_reg <= colour_reg;
            bdone_reg   <= done_upd;
        end
        if (out_load)
        begin
            out_x_reg      <= px;
            out_y_reg      <= py;
            out_idx_reg    <= idx_reg;
            out_colour_reg <= bcolour_reg;
            out_last_reg   <= (idx_reg == INDEX_LAST);
            out_done_reg   <= (idx_reg == INDEX_LAST) && bdone_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, out_colour_reg, out_idx_reg, out_y_reg, out_x_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_done_reg;

    a_idx_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != '0) |-> burst_reg)
        else $error("point counter running outside a burst");

    a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && out_done_reg) |-> (out_last_reg && (out_idx_reg == INDEX_LAST)))
        else $error("circle done flagged away from the eighth point");

    a_start_arms: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (s_tuser == CMD_START)) |=> (active_reg && (sx_reg == '0)))
        else $error("start word did not arm the generator");

endmodule

@@ verif/tb_midpoint_circle_outline_top.sv @@
`timescale 1ns / 100ps

module tb_midpoint_circle_outline_top;

    import mco_pkg::*;

    localparam int RADIUS_LIMIT = 4095;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        logic                  cmd;
        coord_t                cx;
        coord_t                cy;
        logic [RADIUS_W-1:0]   radius;
        logic [CHAN_W-1:0]     red;
        logic [CHAN_W-1:0]     green;
        logic [CHAN_W-1:0]     blue;
        logic [CHAN_W-1:0]     alpha;
    } draw_word_t;

    typedef struct {
        point_t                px;
        point_t                py;
        logic [INDEX_W-1:0]    idx;
        logic [COLOUR_W-1:0]   colour;
        logic                  last;
        logic                  done;
    } outline_point_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                s_tuser = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;
    logic                m_tuser;

    draw_word_t     pending_words[$];
    outline_point_t expected_points[$];

    int  idle_pct = 0;
    int  stall_pct = 0;
    int  error_count = 0;
    int  words_queued = 0;
    logic hold_armed = 1'b0;
    logic hold_done = 1'b0;
    int  hold_cnt = 0;

    // predictor state
    logic                pred_active = 1'b0;
    coord_t              pred_col = '0;
    coord_t              pred_row = '0;
    int                  pred_sx = 0;
    int                  pred_sy = 0;
    dec_t                pred_dec = '0;
    logic [COLOUR_W-1:0] pred_colour = '0;

    midpoint_circle_outline_top #(
        .RADIUS_MAX (RADIUS_LIMIT)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic predict_points(input draw_word_t w);
        int             rad;
        int             ox[8];
        int             oy[8];
        int             c;
        int             r;
        logic           done;
        outline_point_t p;
        if (w.cmd == CMD_START)
        begin
            rad = (int'(w.radius) > RADIUS_LIMIT) ? RADIUS_LIMIT : int'(w.radius);
            pred_col    = w.cx;
            pred_row    = w.cy;
            pred_sx     = 0;
            pred_sy     = rad;
            pred_dec    = dec_t'((5 - 4 * rad) / 8);
            pred_colour = {w.red, w.green, w.blue, w.alpha};
            pred_active = 1'b1;
        end
        else if (!pred_active || pred_sx > pred_sy)
        begin
            pred_active = 1'b0;
        end
        else
        begin
            c = int'(pred_col);
            r = int'(pred_row);
            ox[0] = c + pred_sx; oy[0] = r + pred_sy;
            ox[1] = c - pred_sx; oy[1] = r + pred_sy;
            ox[2] = c + pred_sx; oy[2] = r - pred_sy;
            ox[3] = c - pred_sx; oy[3] = r - pred_sy;
            ox[4] = c + pred_sy; oy[4] = r + pred_sx;
            ox[5] = c - pred_sy; oy[5] = r + pred_sx;
            ox[6] = c + pred_sy; oy[6] = r - pred_sx;
            ox[7] = c - pred_sy; oy[7] = r - pred_sx;
            if (pred_dec < 0)
            begin
                pred_dec = dec_t'(int'(pred_dec) + 2 * pred_sx + 1);
            end
            else
            begin
                pred_dec = dec_t'(int'(pred_dec) + 2 * (pred_sx - pred_sy) + 1);
                pred_sy  = pred_sy - 1;
            end
            pred_sx = pred_sx + 1;
            done = (pred_sx > pred_sy);
            if (done)
            begin
                pred_active = 1'b0;
            end
            for (int k = 0; k < 8; k++)
            begin
                p.px     = point_t'(ox[k]);
                p.py     = point_t'(oy[k]);
                p.idx    = INDEX_W'(k);
                p.colour = pred_colour;
                p.last   = (INDEX_W'(k) == INDEX_LAST);
                p.done   = (INDEX_W'(k) == INDEX_LAST) && done;
                expected_points.push_back(p);
            end
        end
    endtask

    task automatic add_word(input logic cmd, input int cx, input int cy, input int rad,
                            input logic [COLOUR_W-1:0] colour);
        draw_word_t w;
        w.cmd    = cmd;
        w.cx     = coord_t'(cx);
        w.cy     = coord_t'(cy);
        w.radius = RADIUS_W'(rad);
        {w.red, w.green, w.blue, w.alpha} = colour;
        pending_words.push_back(w);
        words_queued++;
    endtask

    // advance words carry random don't-care data
    task automatic add_advance();
        add_word(CMD_ADVANCE, $urandom_range(0, 8191), $urandom_range(0, 8191),
                 $urandom_range(0, 4095), $urandom);
    endtask

    task automatic add_circle();
        int sel;
        int rad;
        int steps;
        sel = $urandom_range(0, 99);
        if (sel < 80)
        begin
            rad = $urandom_range(0, 24);
        end
        else if (sel < 95)
        begin
            rad = $urandom_range(25, 300);
        end
        else
        begin
            rad = $urandom_range(300, 4095);
        end
        if ($urandom_range(0, 9) == 0)
        begin
            add_advance();
        end
        add_word(CMD_START, $urandom_range(0, 8191), $urandom_range(0, 8191), rad, $urandom);
        steps = (rad * 707) / 1000 + 1;
        sel = $urandom_range(0, 99);
        if (sel < 60)
        begin
            steps = steps;
        end
        else if (sel < 80)
        begin
            steps = steps + $urandom_range(1, 2);
        end
        else
        begin
            steps = $urandom_range(0, steps);
        end
        if (steps > 30)
        begin
            steps = $urandom_range(5, 30);
        end
        repeat (steps)
        begin
            add_advance();
        end
    endtask

    task automatic wait_words_taken();
        while (pending_words.size() != 0 || s_tvalid)
        begin
            @(posedge clk);
        end
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        draw_word_t w;
        logic       offer;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                w.cmd    = s_tuser;
                w.cx     = s_tdata[12:0];
                w.cy     = s_tdata[25:13];
                w.radius = s_tdata[37:26];
                w.red    = s_tdata[45:38];
                w.green  = s_tdata[53:46];
                w.blue   = s_tdata[61:54];
                w.alpha  = s_tdata[69:62];
                predict_points(w);
            end
            if (!s_tvalid || s_tready)
            begin
                offer = (pending_words.size() != 0) && ($urandom_range(0, 99) >= idle_pct);
                if (offer)
                begin
                    w = pending_words.pop_front();
                    s_tdata  <= {2'b00, w.alpha, w.blue, w.green, w.red, w.radius, w.cy, w.cx};
                    s_tuser  <= w.cmd;
                end
                s_tvalid <= offer;
            end
        end
    end

    // receiver ready, with one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_armed && !hold_done)
        begin
            m_tready <= 1'b0;
            hold_cnt <= hold_cnt + 1;
            if (hold_cnt == HOLD_CYCLES - 1)
            begin
                hold_done <= 1'b1;
            end
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // output checker
    always @(posedge clk)
    begin
        outline_point_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_points.size() == 0)
            begin
                report_mismatch("unexpected word", m_tdata, 0);
            end
            else
            begin
                want = expected_points.pop_front();
                if (point_t'(m_tdata[13:0]) !== want.px)
                    report_mismatch("point_x", m_tdata[13:0], want.px);
                if (point_t'(m_tdata[27:14]) !== want.py)
                    report_mismatch("point_y", m_tdata[27:14], want.py);
                if (m_tdata[30:28] !== want.idx)
                    report_mismatch("point_index", m_tdata[30:28], want.idx);
                if (m_tdata[62:31] !== want.colour)
                    report_mismatch("pixel_colour", m_tdata[62:31], want.colour);
                if (m_tlast !== want.last)
                    report_mismatch("last_of_step", m_tlast, want.last);
                if (m_tuser !== want.done)
                    report_mismatch("circle_done", m_tuser, want.done);
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("tb_midpoint_circle_outline_top: FAIL");
        $finish;
    end

    initial
    begin
        hold_armed = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: zero radius, idle advance, extreme centers and radii, abandon
        add_word(CMD_START, 0, 0, 0, 32'h01020304);
        add_advance();
        add_advance();
        add_word(CMD_START, 4095, -4096, 4095, 32'hffffffff);
        repeat (3) add_advance();
        add_word(CMD_START, -4096, 4095, 1, 32'h00000000);
        add_advance();
        add_advance();
        add_word(CMD_START, -4096, -4096, 4095, 32'h807f55aa);
        repeat (2) add_advance();
        add_word(CMD_START, 4095, 4095, 4095, 32'h7f80aa55);
        repeat (2) add_advance();
        add_word(CMD_START, 100, -50, 3, 32'hc3a5e10f);
        repeat (4) add_advance();
        add_advance();

        // phase 0: no idling, receiver hold-off at the start
        while (words_queued < 110) add_circle();
        wait_words_taken();

        idle_pct = 64;
        while (words_queued < 215) add_circle();
        wait_words_taken();

        idle_pct  = 0;
        stall_pct = 64;
        while (words_queued < 320) add_circle();
        wait_words_taken();

        idle_pct  = 9;
        stall_pct = 9;
        while (words_queued < 425) add_circle();
        wait_words_taken();

        while (expected_points.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("tb_midpoint_circle_outline_top: PASS");
        end
        else
        begin
            $display("tb_midpoint_circle_outline_top: FAIL");
        end
        $finish;
    end

endmodule
